/* src/aenv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package aenv_pkg;

    // configuration port shape
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int LEVEL_W     = 16;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_LEN  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DECAY_LEN   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SUSTAIN_LEN = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_LEN = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PEAK_LEVEL  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_LEVEL  = 3'd5;

    // envelope segments
    typedef enum logic [2:0] {
        SEG_IDLE    = 3'd0,
        SEG_ATTACK  = 3'd1,
        SEG_DECAY   = 3'd2,
        SEG_SUSTAIN = 3'd3,
        SEG_RELEASE = 3'd4
    } t_seg;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_LOAD   = 3'd1,
        OP_DIV    = 3'd2,
        OP_RD_A   = 3'd3,
        OP_RD_B   = 3'd4,
        OP_MUL    = 3'd5,
        OP_INTERP = 3'd6,
        OP_SCALE  = 3'd7
    } t_op;

    // controller to datapath
    typedef struct packed {
        t_op  op;
        logic level;   // form the output level from the scaled product
        t_seg seg;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_last;
    } t_stat;

endpackage

`default_nettype wire

/* src/aenv_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module aenv_regs #(
    parameter int LEN_BITS = 20
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_we,
    input  wire [aenv_pkg::CFG_INDEX_W-1:0]   i_index,
    input  wire [aenv_pkg::CFG_DATA_W-1:0]    i_data,
    output logic [LEN_BITS-1:0]               o_attack_len,
    output logic [LEN_BITS-1:0]               o_decay_len,
    output logic [LEN_BITS-1:0]               o_sustain_len,
    output logic [LEN_BITS-1:0]               o_release_len,
    output logic [aenv_pkg::LEVEL_W-1:0]      o_peak_level,
    output logic [aenv_pkg::LEVEL_W-1:0]      o_hold_level
);

    logic [LEN_BITS-1:0]          r_attack_len;
    logic [LEN_BITS-1:0]          r_decay_len;
    logic [LEN_BITS-1:0]          r_sustain_len;
    logic [LEN_BITS-1:0]          r_release_len;
    logic [aenv_pkg::LEVEL_W-1:0] r_peak_level;
    logic [aenv_pkg::LEVEL_W-1:0] r_hold_level;

    // register file, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_len  <= '0;
            r_decay_len   <= '0;
            r_sustain_len <= '0;
            r_release_len <= '0;
            r_peak_level  <= 16'hFFFF;
            r_hold_level  <= 16'h8000;
        end else if (i_we) begin
            case (i_index)
                aenv_pkg::REG_ATTACK_LEN:  r_attack_len  <= i_data[LEN_BITS-1:0];
                aenv_pkg::REG_DECAY_LEN:   r_decay_len   <= i_data[LEN_BITS-1:0];
                aenv_pkg::REG_SUSTAIN_LEN: r_sustain_len <= i_data[LEN_BITS-1:0];
                aenv_pkg::REG_RELEASE_LEN: r_release_len <= i_data[LEN_BITS-1:0];
                aenv_pkg::REG_PEAK_LEVEL:  r_peak_level  <= i_data[aenv_pkg::LEVEL_W-1:0];
                aenv_pkg::REG_HOLD_LEVEL:  r_hold_level  <= i_data[aenv_pkg::LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_attack_len  = r_attack_len;
    assign o_decay_len   = r_decay_len;
    assign o_sustain_len = r_sustain_len;
    assign o_release_len = r_release_len;
    assign o_peak_level  = r_peak_level;
    assign o_hold_level  = r_hold_level;

endmodule

`default_nettype wire

/* src/aenv_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module aenv_dp #(
    parameter int LEN_BITS     = 20,
    parameter int CURVE_POINTS = 256
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  aenv_pkg::t_cmd                i_cmd,
    input  wire [LEN_BITS-1:0]            i_pos,
    input  wire [LEN_BITS-1:0]            i_len,
    input  wire [aenv_pkg::LEVEL_W-1:0]   i_peak,
    input  wire [aenv_pkg::LEVEL_W-1:0]   i_hold,
    output aenv_pkg::t_stat               o_stat,
    output logic [aenv_pkg::LEVEL_W-1:0]  o_level
);

    localparam int CPW  = $clog2(CURVE_POINTS + 1);   // table index bits
    localparam int QW   = CPW + 16;                   // quotient bits: index plus fraction
    localparam int NUMW = LEN_BITS + 1 + CPW;         // phase numerator times points
    localparam int CNTW = $clog2(QW);

    typedef logic [16:0] t_curve [0:CURVE_POINTS];

    // unsigned quotient by restoring steps, only used while the table is built
    function automatic logic [63:0] div_u64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int j = 63; j >= 0; j--) begin
            rem = {rem[63:0], a[j]};
            if (rem >= {1'b0, b}) begin
                rem  = rem - {1'b0, b};
                q[j] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^x in Q30 by a 25-term Taylor sum
    function automatic logic [63:0] exp_q30(input logic [63:0] x);
        logic [63:0] sum;
        logic [63:0] term;
        sum  = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int n = 1; n <= 24; n++) begin
            term = div_u64((term * x) >> 30, 64'(n));
            sum  = sum + term;
        end
        return sum;
    endfunction

    // normalized curve (e^x-1)/(e-1), Q1.16, built at elaboration
    function automatic t_curve build_curve();
        t_curve      c;
        logic [63:0] den;
        logic [63:0] x;
        logic [63:0] num;
        den = exp_q30(64'd1 << 30) - (64'd1 << 30);
        for (int k = 0; k <= CURVE_POINTS; k++) begin
            x    = div_u64(64'(k) << 30, 64'(CURVE_POINTS));
            num  = exp_q30(x) - (64'd1 << 30);
            c[k] = 17'(div_u64((num << 16) + (den >> 1), den));
        end
        return c;
    endfunction

    localparam t_curve CURVE = build_curve();

    logic [LEN_BITS-1:0]          r_d;
    logic [LEN_BITS-1:0]          r_rem;
    logic [QW-1:0]                r_nb;
    logic [QW-1:0]                r_q;
    logic [CNTW-1:0]              r_cnt;
    logic                         r_full;
    logic                         r_rise;
    logic [aenv_pkg::LEVEL_W-1:0] r_amp;
    logic [16:0]                  r_a;
    logic [16:0]                  r_b;
    logic [16:0]                  r_g;
    logic [32:0]                  r_prod;
    logic [aenv_pkg::LEVEL_W-1:0] r_level;

    logic                         w_att;
    logic [LEN_BITS:0]            w_i;
    logic [NUMW-1:0]              w_num;
    logic [LEN_BITS:0]            w_t;
    logic                         w_ge;
    logic [CPW-1:0]               w_k;
    logic [15:0]                  w_f;
    logic                         w_sat;
    logic [CPW-1:0]               w_addr;
    logic [16:0]                  w_diff;
    logic [33:0]                  w_round;
    logic [aenv_pkg::LEVEL_W-1:0] w_sc;

    // phase i/d: attack runs p/(len-1), the others (p+1)/len
    assign w_att = (i_cmd.seg == aenv_pkg::SEG_ATTACK);
    assign w_i   = w_att ? {1'b0, i_pos} : ({1'b0, i_pos} + 1'b1);
    assign w_num = NUMW'(w_i) * NUMW'(CURVE_POINTS);

    // restoring divide step
    assign w_t  = {r_rem, r_nb[QW-1]};
    assign w_ge = (w_t >= {1'b0, r_d});

    // table lookup, end point once the phase reaches one
    assign w_k    = r_q[QW-1:16];
    assign w_f    = r_q[15:0];
    assign w_sat  = r_full || (w_k >= CPW'(CURVE_POINTS));
    assign w_addr = w_sat ? CPW'(CURVE_POINTS)
                  : ((i_cmd.op == aenv_pkg::OP_RD_B) ? (w_k + 1'b1) : w_k);

    assign w_diff  = r_b - r_a;
    assign w_round = 34'(r_prod) + 34'd32768;
    assign w_sc    = w_round[31:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.op == aenv_pkg::OP_LOAD) begin
            r_cnt <= CNTW'(QW - 1);
        end else if (i_cmd.op == aenv_pkg::OP_DIV) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            aenv_pkg::OP_LOAD: begin
                r_d    <= w_att ? (i_len - 1'b1) : i_len;
                r_full <= w_att && (i_len <= LEN_BITS'(1));
                r_rem  <= w_num[NUMW-2:CPW];
                r_nb   <= {w_num[CPW-1:0], 16'b0};
                r_q    <= '0;
                r_rise <= (i_hold > i_peak);
                case (i_cmd.seg)
                    aenv_pkg::SEG_ATTACK: r_amp <= i_peak;
                    aenv_pkg::SEG_DECAY:  r_amp <= (i_hold > i_peak) ? (i_hold - i_peak)
                                                                     : (i_peak - i_hold);
                    default:              r_amp <= i_hold;
                endcase
            end
            aenv_pkg::OP_DIV: begin
                r_rem <= w_ge ? LEN_BITS'(w_t - {1'b0, r_d}) : w_t[LEN_BITS-1:0];
                r_q   <= {r_q[QW-2:0], w_ge};
                r_nb  <= {r_nb[QW-2:0], 1'b0};
            end
            aenv_pkg::OP_RD_A:   r_a    <= CURVE[w_addr];
            aenv_pkg::OP_RD_B:   r_b    <= CURVE[w_addr];
            aenv_pkg::OP_MUL:    r_prod <= 33'(w_diff) * 33'(w_f);
            aenv_pkg::OP_INTERP: r_g    <= r_a + 17'(w_round >> 16);
            aenv_pkg::OP_SCALE:  r_prod <= 33'(r_amp) * 33'(r_g);
            default: ;
        endcase
    end

    // final level from the rounded product; sustain gives the hold level
    always_ff @(posedge i_clk) begin
        if (i_cmd.level) begin
            case (i_cmd.seg)
                aenv_pkg::SEG_ATTACK:  r_level <= w_sc;
                aenv_pkg::SEG_DECAY:   r_level <= r_rise ? (i_peak + w_sc) : (i_peak - w_sc);
                aenv_pkg::SEG_SUSTAIN: r_level <= i_hold;
                aenv_pkg::SEG_RELEASE: r_level <= i_hold - w_sc;
                default:               r_level <= '0;
            endcase
        end
    end

    assign o_stat.div_last = (r_cnt == '0);
    assign o_level         = r_level;

endmodule

`default_nettype wire

/* src/aenv_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module aenv_ctrl #(
    parameter int LEN_BITS = 20
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // sample tick requests
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire                           i_restart,
    // result requests
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic [aenv_pkg::LEVEL_W-1:0]  o_out_level,
    output logic                          o_out_last,
    output logic                          o_out_idle,
    // segment lengths
    input  wire [LEN_BITS-1:0]            i_attack_len,
    input  wire [LEN_BITS-1:0]            i_decay_len,
    input  wire [LEN_BITS-1:0]            i_sustain_len,
    input  wire [LEN_BITS-1:0]            i_release_len,
    // datapath
    output aenv_pkg::t_cmd                o_cmd,
    output logic [LEN_BITS-1:0]           o_pos,
    output logic [LEN_BITS-1:0]           o_len,
    input  aenv_pkg::t_stat               i_stat,
    input  wire [aenv_pkg::LEVEL_W-1:0]   i_level
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETTLE_A,
        ST_LOAD,
        ST_DIV,
        ST_RD_A,
        ST_RD_B,
        ST_MUL,
        ST_INTERP,
        ST_SCALE,
        ST_LEVEL,
        ST_SETTLE_B,
        ST_OUT
    } t_state;

    t_state                       r_state;
    aenv_pkg::t_seg               r_seg;
    logic [LEN_BITS-1:0]          r_pos;
    logic                         r_res_idle;
    logic                         r_res_last;
    logic                         r_out_valid;
    logic [aenv_pkg::LEVEL_W-1:0] r_out_level;
    logic                         r_out_last;
    logic                         r_out_idle;

    logic [LEN_BITS-1:0]          w_len;
    logic                         w_done;   // current segment finished or empty

    function automatic aenv_pkg::t_seg next_seg(input aenv_pkg::t_seg s);
        case (s)
            aenv_pkg::SEG_ATTACK:  return aenv_pkg::SEG_DECAY;
            aenv_pkg::SEG_DECAY:   return aenv_pkg::SEG_SUSTAIN;
            aenv_pkg::SEG_SUSTAIN: return aenv_pkg::SEG_RELEASE;
            default:               return aenv_pkg::SEG_IDLE;
        endcase
    endfunction

    // live length of the current segment
    always_comb begin
        case (r_seg)
            aenv_pkg::SEG_ATTACK:  w_len = i_attack_len;
            aenv_pkg::SEG_DECAY:   w_len = i_decay_len;
            aenv_pkg::SEG_SUSTAIN: w_len = i_sustain_len;
            aenv_pkg::SEG_RELEASE: w_len = i_release_len;
            default:               w_len = '0;
        endcase
    end

    assign w_done = (r_seg != aenv_pkg::SEG_IDLE) && (r_pos >= w_len);

    // datapath command per state
    always_comb begin
        o_cmd.seg   = r_seg;
        o_cmd.level = (r_state == ST_LEVEL);
        case (r_state)
            ST_LOAD:   o_cmd.op = aenv_pkg::OP_LOAD;
            ST_DIV:    o_cmd.op = aenv_pkg::OP_DIV;
            ST_RD_A:   o_cmd.op = aenv_pkg::OP_RD_A;
            ST_RD_B:   o_cmd.op = aenv_pkg::OP_RD_B;
            ST_MUL:    o_cmd.op = aenv_pkg::OP_MUL;
            ST_INTERP: o_cmd.op = aenv_pkg::OP_INTERP;
            ST_SCALE:  o_cmd.op = aenv_pkg::OP_SCALE;
            default:   o_cmd.op = aenv_pkg::OP_NONE;
        endcase
    end

    // sequencer, segment state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seg       <= aenv_pkg::SEG_IDLE;
            r_pos       <= '0;
            r_res_idle  <= 1'b0;
            r_res_last  <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_level <= '0;
            r_out_last  <= 1'b0;
            r_out_idle  <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        if (i_restart) begin
                            r_seg <= aenv_pkg::SEG_ATTACK;
                            r_pos <= '0;
                        end
                        r_state <= ST_SETTLE_A;
                    end
                end
                // skip finished or empty segments, one per cycle
                ST_SETTLE_A: begin
                    if (w_done) begin
                        r_seg <= next_seg(r_seg);
                        r_pos <= '0;
                    end else if (r_seg == aenv_pkg::SEG_IDLE) begin
                        r_pos      <= '0;
                        r_res_idle <= 1'b1;
                        r_res_last <= 1'b0;
                        r_state    <= ST_OUT;
                    end else begin
                        r_res_idle <= 1'b0;
                        r_state    <= ST_LOAD;
                    end
                end
                ST_LOAD:   r_state <= ST_DIV;
                ST_DIV: begin
                    if (i_stat.div_last) begin
                        r_state <= ST_RD_A;
                    end
                end
                ST_RD_A:   r_state <= ST_RD_B;
                ST_RD_B:   r_state <= ST_MUL;
                ST_MUL:    r_state <= ST_INTERP;
                ST_INTERP: r_state <= ST_SCALE;
                ST_SCALE:  r_state <= ST_LEVEL;
                ST_LEVEL: begin
                    r_pos   <= r_pos + 1'b1;
                    r_state <= ST_SETTLE_B;
                end
                ST_SETTLE_B: begin
                    if (w_done) begin
                        r_seg <= next_seg(r_seg);
                        r_pos <= '0;
                    end else begin
                        r_res_last <= (r_seg == aenv_pkg::SEG_IDLE);
                        if (r_seg == aenv_pkg::SEG_IDLE) begin
                            r_pos <= '0;
                        end
                        r_state <= ST_OUT;
                    end
                end
                // hand the result over once the output slot is free
                ST_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_level <= r_res_idle ? '0 : i_level;
                        r_out_last  <= r_res_last;
                        r_out_idle  <= r_res_idle;
                        r_state     <= ST_IDLE;
                    end
                end
                default:   r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_level = r_out_level;
    assign o_out_last  = r_out_last;
    assign o_out_idle  = r_out_idle;
    assign o_pos       = r_pos;
    assign o_len       = w_len;

endmodule

`default_nettype wire

/* src/exponential_adsr_envelope_top.sv */
// Exponential ADSR envelope generator. Every request on the input stream is one audio
// sample tick and yields exactly one result: the envelope level (Q0.16) in tdata, tlast on
// the final sample of the envelope, tuser set while no envelope runs (level 0). A tick with restart
// set begins a new attack. Attack, decay and release follow (e^x-1)/(e-1) from a table of
// CURVE_POINTS+1 points with linear interpolation; segment lengths are given in samples and
// a zero length skips the segment. The phase comes from a bit-serial divider that yields one
// quotient bit per cycle. A new tick is taken while the previous result still waits on the
// output register.
`timescale 1ns / 1ps
`default_nettype none

module exponential_adsr_envelope_top #(
    parameter int LEN_BITS     = 20,
    parameter int CURVE_POINTS = 256
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // configuration writes
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire [aenv_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire [aenv_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // sample ticks
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire [7:0]                         s_axis_tdata,   // [0] restart, [7:1] zero
    // levels
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    output logic [15:0]                       m_axis_tdata,   // [15:0] level
    output logic                              m_axis_tlast,
    output logic                              m_axis_tuser    // [0] idle
);

    logic [LEN_BITS-1:0]          w_attack_len;
    logic [LEN_BITS-1:0]          w_decay_len;
    logic [LEN_BITS-1:0]          w_sustain_len;
    logic [LEN_BITS-1:0]          w_release_len;
    logic [aenv_pkg::LEVEL_W-1:0] w_peak_level;
    logic [aenv_pkg::LEVEL_W-1:0] w_hold_level;
    aenv_pkg::t_cmd               w_cmd;
    aenv_pkg::t_stat              w_stat;
    logic [LEN_BITS-1:0]          w_pos;
    logic [LEN_BITS-1:0]          w_len;
    logic [aenv_pkg::LEVEL_W-1:0] w_level;

    assign o_cfg_ready = 1'b1;

    aenv_regs #(
        .LEN_BITS (LEN_BITS)
    ) u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_we          (i_cfg_valid),
        .i_index       (i_cfg_index),
        .i_data        (i_cfg_data),
        .o_attack_len  (w_attack_len),
        .o_decay_len   (w_decay_len),
        .o_sustain_len (w_sustain_len),
        .o_release_len (w_release_len),
        .o_peak_level  (w_peak_level),
        .o_hold_level  (w_hold_level)
    );

    aenv_ctrl #(
        .LEN_BITS (LEN_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_restart     (s_axis_tdata[0]),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_level   (m_axis_tdata),
        .o_out_last    (m_axis_tlast),
        .o_out_idle    (m_axis_tuser),
        .i_attack_len  (w_attack_len),
        .i_decay_len   (w_decay_len),
        .i_sustain_len (w_sustain_len),
        .i_release_len (w_release_len),
        .o_cmd         (w_cmd),
        .o_pos         (w_pos),
        .o_len         (w_len),
        .i_stat        (w_stat),
        .i_level       (w_level)
    );

    aenv_dp #(
        .LEN_BITS     (LEN_BITS),
        .CURVE_POINTS (CURVE_POINTS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_pos   (w_pos),
        .i_len   (w_len),
        .i_peak  (w_peak_level),
        .i_hold  (w_hold_level),
        .o_stat  (w_stat),
        .o_level (w_level)
    );

endmodule

`default_nettype wire

/* bench/tb_exponential_adsr_envelope_top.sv */
`timescale 1ns / 1ps

module tb_exponential_adsr_envelope_top;

    localparam int LEN_BITS     = 20;
    localparam int CURVE_POINTS = 256;
    localparam int RANDOM_TICKS = 450;
    localparam int STALL_LIMIT  = 4000;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 100;
    localparam int SPAN_CAP     = 40;
    localparam int DIR_ROWS     = 38;

    localparam longint unsigned Q30 = 64'd1 << 30;
    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

    // indexes the block has no register for, and the index that tick rows carry
    localparam logic [aenv_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [aenv_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;
    localparam logic [aenv_pkg::CFG_INDEX_W-1:0] NO_REG      = aenv_pkg::REG_ATTACK_LEN;

    typedef struct packed {
        logic [15:0] level;
        logic        last;
        logic        idle;
    } env_sample_t;

    localparam env_sample_t IDLE_OUT  = '{16'd0,     1'b0, 1'b1};
    localparam env_sample_t PEAK_LAST = '{16'd65535, 1'b1, 1'b0};
    localparam env_sample_t HOLD_MID  = '{16'd32768, 1'b0, 1'b0};
    localparam env_sample_t HOLD_LAST = '{16'd32768, 1'b1, 1'b0};
    localparam env_sample_t NO_CHECK  = '{16'd0,     1'b0, 1'b0};

    typedef enum bit {ROW_TICK, ROW_CFG} row_kind_t;
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_mode_t;

    typedef struct packed {
        row_kind_t                        kind;
        logic [aenv_pkg::CFG_INDEX_W-1:0] index;
        logic [aenv_pkg::CFG_DATA_W-1:0]  data;
        bit                               restart;
        bit                               typed;
        env_sample_t                      want;
    } dir_row_t;

    // DUT ports
    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [aenv_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [aenv_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [7:0]                       s_axis_tdata = '0;   // [0] restart, [7:1] zero
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [15:0]                      m_axis_tdata;        // [15:0] level
    logic                             m_axis_tlast;
    logic                             m_axis_tuser;        // [0] idle

    // envelope model state and register copies
    logic [31:0]         curve_tab [0:CURVE_POINTS];
    aenv_pkg::t_seg      env_seg = aenv_pkg::SEG_IDLE;
    logic [LEN_BITS-1:0] env_pos = '0;
    logic [LEN_BITS-1:0] atk_len = '0;
    logic [LEN_BITS-1:0] dcy_len = '0;
    logic [LEN_BITS-1:0] sus_len = '0;
    logic [LEN_BITS-1:0] rel_len = '0;
    logic [15:0]         lvl_peak = 16'd65535;
    logic [15:0]         lvl_hold = 16'd32768;

    env_sample_t pending_levels [$];
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          burst_left = 0;
    int          ticks_sent = 0;
    rx_mode_t    rx_mode = RX_OPEN;
    int          rx_left = 0;

    dir_row_t dir_rows [DIR_ROWS] = '{
        // tick while idle, then restart with every length zero
        '{ROW_TICK, NO_REG,                    32'd0,         1'b0, 1'b1, IDLE_OUT},
        '{ROW_TICK, NO_REG,                    32'd0,         1'b1, 1'b1, IDLE_OUT},
        // one-sample attack lands on the peak; upper data bits are dropped
        '{ROW_CFG,  aenv_pkg::REG_ATTACK_LEN,  32'hABC0_0001, 1'b0, 1'b0, NO_CHECK},
        '{ROW_TICK, NO_REG,                    32'd0,         1'b1, 1'b1, PEAK_LAST},
        '{ROW_TICK, NO_REG,                    32'd0,         1'b0, 1'b1, IDLE_OUT},
        // sustain only
        '{ROW_CFG,  aenv_pkg::REG_ATTACK_LEN,  32'd0,         1'b0, 1'b0, NO_CHECK},
        '{ROW_CFG,  aenv_pkg::REG_SUSTAIN_LEN, 32'd2,         1'b0, 1'b0, NO_CHECK},
        '{ROW_TICK, NO_REG,                    32'd0,         1'b1, 1'b1, HOLD_MID},
        '{ROW_TICK, NO_REG,                    32'd0,         1'b0, 1'b1, HOLD_LAST},
        // writes to indexes without a register change nothing
        '{ROW_CFG,  REG_SPARE_A,               32'd7,         1'b0, 1'b0, NO_CHECK},
        '{ROW_CFG,  REG_SPARE_B,               32'hFFFF_FFFF, 1'b0, 1'b0, NO_CHECK},
        '{ROW_TICK, NO_REG,                    32'd0,         1'b1, 1'b1, HOLD_MID},
        '{ROW_TICK, NO_REG,                    32'd0,         1'b0, 1'b1, HOLD_LAST},
        // full envelope down to a zero hold, restarted midway
        '{ROW_CFG,  aenv_pkg::REG_ATTACK_LEN,  32'd4,         1'b0, 1'b0, NO_CHECK},
        '{ROW_CFG,  aenv_pkg::REG_DECAY_LEN,   32'd3,         1'b0, 1'b0, NO_CHECK},
        '{ROW_CFG,  aenv_pkg::REG_SUSTAIN_LEN, 32'd1,         1'b0, 1'b0, NO_CHECK},
        '{ROW_CFG,  aenv_pkg::REG_RELEASE_LEN, 32'd3,         1'b0, 1'b0, NO_CHECK},
        '{ROW_CFG,  aenv_pkg::REG_HOLD_LEVEL,  32'h1234_0000, 1'b0, 1'b0, NO_CHECK},
        '{ROW_TICK, NO_REG,                    32'd0,         1'b1, 1'b0, NO_CHECK},
        '{ROW_TICK, NO_REG,                    32'd0,         1'b0, 1'b0, NO_CHECK},
        '{ROW_TICK, NO_REG,                    32'd0,         1'b0, 1'b0, NO_CHECK},
        '{ROW_TICK, NO_REG,                    32'd0,         1'b0, 1'b0, NO_CHECK},
        '{ROW_TICK, NO_REG,                    32'd0,         1'b0, 1'b0, NO_CHECK},
        '{ROW_TICK, NO_REG,                    32'd0,         1'b1, 1'b0, NO_CHECK},
        '{ROW_TICK, NO_REG,                    32'd0,         1'b0, 1'b0, NO_CHECK},
        '{ROW_TICK, NO_REG,                    32'd0,         1'b0, 1'b0, NO_CHECK},
        '{ROW_TICK, NO_REG,                    32'd0,         1'b0, 1'b0, NO_CHECK},
        // hold above a zero peak, longest release; written mid-envelope
        '{ROW_CFG,  aenv_pkg::REG_PEAK_LEVEL,  32'hFFFF_0000, 1'b0, 1'b0, NO_CHECK},
        '{ROW_CFG,  aenv_pkg::REG_HOLD_LEVEL,  32'h0000_FFFF, 1'b0, 1'b0, NO_CHECK},
        '{ROW_CFG,  aenv_pkg::REG_DECAY_LEN,   32'd1,         1'b0, 1'b0, NO_CHECK},
        '{ROW_CFG,  aenv_pkg::REG_RELEASE_LEN, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_CHECK},
        '{ROW_TICK, NO_REG,                    32'd0,         1'b0, 1'b0, NO_CHECK},
        '{ROW_TICK, NO_REG,                    32'd0,         1'b1, 1'b0, NO_CHECK},
        '{ROW_TICK, NO_REG,                    32'd0,         1'b0, 1'b0, NO_CHECK},
        '{ROW_TICK, NO_REG,                    32'd0,         1'b0, 1'b0, NO_CHECK},
        '{ROW_TICK, NO_REG,                    32'd0,         1'b0, 1'b0, NO_CHECK},
        '{ROW_TICK, NO_REG,                    32'd0,         1'b0, 1'b0, NO_CHECK},
        '{ROW_TICK, NO_REG,                    32'd0,         1'b0, 1'b0, NO_CHECK}
    };

    exponential_adsr_envelope_top #(
        .LEN_BITS    (LEN_BITS),
        .CURVE_POINTS(CURVE_POINTS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    // e^x in Q30 from a truncated Taylor series
    function automatic longint unsigned exp_q30(input longint unsigned x);
        longint unsigned sum;
        longint unsigned term;
        sum  = Q30;
        term = Q30;
        for (longint unsigned n = 1; n <= 24; n++) begin
            term = ((term * x) >> 30) / n;
            sum  = sum + term;
        end
        return sum;
    endfunction

    // interpolated curve value for phase i/d, scaled by 65536
    function automatic longint unsigned curve_at(input longint unsigned i,
                                                 input longint unsigned d);
        longint unsigned u;
        longint unsigned k;
        longint unsigned f;
        longint unsigned a;
        longint unsigned b;
        u = ((i * CURVE_POINTS) << 16) / d;
        k = u >> 16;
        f = u & 64'hFFFF;
        if (k >= CURVE_POINTS)
            return curve_tab[CURVE_POINTS];
        a = curve_tab[k];
        b = curve_tab[k + 1];
        return a + (((b - a) * f + 32768) >> 16);
    endfunction

    function automatic longint unsigned scale_q16(input longint unsigned a,
                                                  input longint unsigned g);
        return (a * g + 32768) >> 16;
    endfunction

    function automatic logic [LEN_BITS-1:0] seg_length(input aenv_pkg::t_seg s);
        case (s)
            aenv_pkg::SEG_ATTACK:  return atk_len;
            aenv_pkg::SEG_DECAY:   return dcy_len;
            aenv_pkg::SEG_SUSTAIN: return sus_len;
            aenv_pkg::SEG_RELEASE: return rel_len;
            default:               return '0;
        endcase
    endfunction

    // step past segments that are empty or already used up
    function automatic void skip_finished();
        while (env_seg != aenv_pkg::SEG_IDLE && env_pos >= seg_length(env_seg)) begin
            case (env_seg)
                aenv_pkg::SEG_ATTACK:  env_seg = aenv_pkg::SEG_DECAY;
                aenv_pkg::SEG_DECAY:   env_seg = aenv_pkg::SEG_SUSTAIN;
                aenv_pkg::SEG_SUSTAIN: env_seg = aenv_pkg::SEG_RELEASE;
                default:               env_seg = aenv_pkg::SEG_IDLE;
            endcase
            env_pos = '0;
        end
    endfunction

    function automatic logic [15:0] current_level();
        logic [LEN_BITS-1:0] len;
        longint unsigned     g;
        len = seg_length(env_seg);
        case (env_seg)
            aenv_pkg::SEG_ATTACK: begin
                g = (len <= 1) ? 64'd65536 : curve_at(env_pos, len - 1);
                return 16'(scale_q16(lvl_peak, g));
            end
            aenv_pkg::SEG_DECAY: begin
                g = curve_at(env_pos + 1, len);
                if (lvl_hold <= lvl_peak)
                    return 16'(lvl_peak - scale_q16(lvl_peak - lvl_hold, g));
                return 16'(lvl_peak + scale_q16(lvl_hold - lvl_peak, g));
            end
            aenv_pkg::SEG_SUSTAIN: return lvl_hold;
            aenv_pkg::SEG_RELEASE: begin
                g = curve_at(env_pos + 1, len);
                return 16'(lvl_hold - scale_q16(lvl_hold, g));
            end
            default: return '0;
        endcase
    endfunction

    // one sample tick of the envelope
    function automatic env_sample_t envelope_advance(input bit restart);
        env_sample_t s;
        if (restart) begin
            env_seg = aenv_pkg::SEG_ATTACK;
            env_pos = '0;
        end
        skip_finished();
        if (env_seg == aenv_pkg::SEG_IDLE) begin
            env_pos = '0;
            return IDLE_OUT;
        end
        s.level = current_level();
        env_pos = env_pos + 1'b1;
        skip_finished();
        s.last  = (env_seg == aenv_pkg::SEG_IDLE);
        s.idle  = 1'b0;
        if (s.last)
            env_pos = '0;
        return s;
    endfunction

    function automatic void log_mismatch(input string what, input env_sample_t want,
                                         input env_sample_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t %0s: expected level %0d last %0b idle %0b, %0s %0d last %0b idle %0b",
                     $realtime, what, want.level, want.last, want.idle,
                     "got level", got.level, got.last, got.idle);
    endfunction

    function automatic logic [aenv_pkg::CFG_DATA_W-1:0] pick_length();
        logic [aenv_pkg::CFG_DATA_W-1:0] junk;
        logic [LEN_BITS-1:0]             len;
        junk = $urandom;
        case ($urandom_range(0, 9))
            0:       len = '0;
            1:       len = LEN_BITS'(1);
            2:       len = LEN_MAX;
            3:       len = LEN_BITS'($urandom_range(0, LEN_MAX));
            default: len = LEN_BITS'($urandom_range(0, 6));
        endcase
        return {junk[aenv_pkg::CFG_DATA_W-1:LEN_BITS], len};
    endfunction

    function automatic logic [aenv_pkg::CFG_DATA_W-1:0] pick_level();
        logic [aenv_pkg::CFG_DATA_W-1:0] junk;
        logic [15:0]                     lvl;
        junk = $urandom;
        case ($urandom_range(0, 4))
            0:       lvl = 16'd0;
            1:       lvl = 16'hFFFF;
            default: lvl = 16'($urandom_range(0, 65535));
        endcase
        return {junk[aenv_pkg::CFG_DATA_W-1:16], lvl};
    endfunction

    // register write; valid stays up so back-to-back writes need no gap
    task automatic write_register(input logic [aenv_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [aenv_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            aenv_pkg::REG_ATTACK_LEN:  atk_len  = data[LEN_BITS-1:0];
            aenv_pkg::REG_DECAY_LEN:   dcy_len  = data[LEN_BITS-1:0];
            aenv_pkg::REG_SUSTAIN_LEN: sus_len  = data[LEN_BITS-1:0];
            aenv_pkg::REG_RELEASE_LEN: rel_len  = data[LEN_BITS-1:0];
            aenv_pkg::REG_PEAK_LEVEL:  lvl_peak = data[15:0];
            aenv_pkg::REG_HOLD_LEVEL:  lvl_hold = data[15:0];
            default: ;
        endcase
    endtask

    // one tick request, sent in bursts with random gaps
    task automatic send_tick(input bit restart, input bit typed, input env_sample_t want);
        env_sample_t predicted;
        int          gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, restart};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = envelope_advance(restart);
        pending_levels.push_back(typed ? want : predicted);
        ticks_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 12);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // hold the sender until every outstanding level has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_levels.size() != 0);
    endtask

    // receiver backpressure, switching between patterns
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 160);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:   m_axis_tready <= rx_left[3];
        endcase
    end

    // result checker
    always @(posedge i_clk) begin : level_check
        env_sample_t got;
        env_sample_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata, m_axis_tlast, m_axis_tuser};
            if (pending_levels.size() == 0) begin
                log_mismatch("unexpected result", NO_CHECK, got);
            end else begin
                want = pending_levels.pop_front();
                if (got.level !== want.level || got.last !== want.last ||
                    got.idle !== want.idle)
                    log_mismatch("level mismatch", want, got);
            end
        end
    end

    // cycles without any accepted request
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("exponential_adsr_envelope_top verification failed");
        $finish;
    end

    initial begin : stimulus
        longint unsigned den;
        int              span;
        int              style;
        int              n;
        int              cut;
        bit              first_restart;
        bit              restart;

        // curve table
        den = exp_q30(Q30) - Q30;
        for (int k = 0; k <= CURVE_POINTS; k++)
            curve_tab[k] = 32'((((exp_q30((longint'(k) << 30) / CURVE_POINTS) - Q30) << 16)
                                + den / 2) / den);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                if (r == 0 || dir_rows[r-1].kind != ROW_CFG)
                    wait_drained();
                write_register(dir_rows[r].index, dir_rows[r].data);
                if (r == DIR_ROWS - 1 || dir_rows[r+1].kind != ROW_CFG)
                    i_cfg_valid <= 1'b0;
            end else begin
                send_tick(dir_rows[r].restart, dir_rows[r].typed, dir_rows[r].want);
            end
        end

        // random phases: new settings, then mostly whole envelopes
        ticks_sent = 0;
        while (ticks_sent < RANDOM_TICKS) begin
            wait_drained();
            for (int idx = 0; idx < 6; idx++) begin
                if ($urandom_range(0, 1))
                    write_register(idx[aenv_pkg::CFG_INDEX_W-1:0],
                                   (idx < 4) ? pick_length() : pick_level());
            end
            if ($urandom_range(0, 7) == 0)
                write_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
            i_cfg_valid <= 1'b0;

            span = int'(atk_len) + int'(dcy_len) + int'(sus_len) + int'(rel_len);
            if (span > SPAN_CAP)
                span = SPAN_CAP;
            style = $urandom_range(0, 9);
            if (style == 0) begin
                // noise
                n = $urandom_range(4, 16);
                for (int i = 0; i < n; i++)
                    send_tick($urandom_range(0, 1) == 1, 1'b0, NO_CHECK);
            end else begin
                n   = (style == 1) ? $urandom_range(0, span) : span + $urandom_range(0, 2);
                cut = (style == 2 && n > 0) ? $urandom_range(1, n) : n + 1;
                first_restart = (style != 3);
                for (int i = 0; i <= n; i++) begin
                    restart = (i == 0) ? first_restart : (i == cut);
                    send_tick(restart, 1'b0, NO_CHECK);
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (pending_levels.size() != 0)
            log_mismatch("missing result", pending_levels.pop_front(), NO_CHECK);
        if (mismatches == 0)
            $display("exponential_adsr_envelope_top verification clean");
        else
            $display("exponential_adsr_envelope_top verification failed");
        $finish;
    end

endmodule
